### sv/dalt_pkg.sv
// Shared constants and types for the dual-axis light tracker.
package dalt_pkg;

  // Default width of one light sensor sample.
  localparam int unsigned SampleBitsDef = 12;

  // Field widths.
  localparam int unsigned TOL_W   = 12;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned TIME_W  = 25;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned DIR_W   = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = TIME_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_NS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN_NS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX_NS = 3'd4;

  // Register reset values.
  localparam logic [TOL_W-1:0]  TOL_RST       = 12'd20;
  localparam logic [STEP_W-1:0] STEP_RST      = 8'd10;
  localparam logic [TIME_W-1:0] PERIOD_RST    = 25'd20000000;
  localparam logic [TIME_W-1:0] PULSE_MIN_RST = 25'd450000;
  localparam logic [TIME_W-1:0] PULSE_MAX_RST = 25'd2450000;

  // Servo angle range in degrees.
  localparam int unsigned ANGLE_FULL = 180;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = ANGLE_W'(ANGLE_FULL);
  localparam logic [ANGLE_W-1:0] ANGLE_HOME = 8'd90;

  // Direction codes.
  localparam logic signed [DIR_W-1:0] DIR_NEG  = -2'sd1;
  localparam logic signed [DIR_W-1:0] DIR_HOLD = 2'sd0;
  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sd1;

  // The pulse span is kept as span / 180 and span % 180.
  localparam int unsigned SPAN_Q_W = 18;
  localparam int unsigned SPAN_R_W = 8;
  localparam int unsigned SPAN_RST = 2450000 - 450000;
  localparam logic [SPAN_Q_W-1:0] SPAN_Q_RST = SPAN_Q_W'(SPAN_RST / ANGLE_FULL);
  localparam logic [SPAN_R_W-1:0] SPAN_R_RST = SPAN_R_W'(SPAN_RST % ANGLE_FULL);
  localparam logic [SPAN_R_W-1:0] SPAN_DIV   = SPAN_R_W'(ANGLE_FULL);

  // span / 180 equals (span >> 2) / 45; a 24-bit reciprocal of 45 with a
  // 29-bit shift gives the exact quotient for the 23-bit shifted span.
  localparam int unsigned SPAN_PRE_SH  = 2;
  localparam int unsigned SPAN_IN_W    = TIME_W - SPAN_PRE_SH;
  localparam int unsigned SPAN_RCP_SH  = 29;
  localparam int unsigned SPAN_RCP_W   = 24;
  localparam int unsigned SPAN_DIV_LOW = ANGLE_FULL >> SPAN_PRE_SH;
  localparam int unsigned SPAN_RCP_VAL =
      ((1 << SPAN_RCP_SH) + SPAN_DIV_LOW - 1) / SPAN_DIV_LOW;
  localparam logic [SPAN_RCP_W-1:0] SPAN_RCP = SPAN_RCP_W'(SPAN_RCP_VAL);
  localparam int unsigned SPAN_PROD_W = SPAN_IN_W + SPAN_RCP_W;

  // Ceiling of (angle * remainder) / 180: the numerator stays below 2**15,
  // so a 16-bit reciprocal with a 23-bit shift gives the exact quotient.
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned RECIP_SH   = 23;
  localparam int unsigned RECIP_W    = 16;
  localparam int unsigned RECIP_VAL  = ((1 << RECIP_SH) + ANGLE_FULL - 1) / ANGLE_FULL;
  localparam logic [RECIP_W-1:0] RECIP_180 = RECIP_W'(RECIP_VAL);
  localparam logic [FRAC_W-1:0]  CEIL_BIAS = FRAC_W'(ANGLE_FULL - 1);

  // Width of the active pulse time; the used time is one bit wider.
  localparam int unsigned ACT_W = TIME_W + 1;

endpackage

### sv/dual_axis_light_tracker.sv
// Dual-axis light tracker: sensor comparison, servo angle tracking and PWM low time.
//
// Each transfer on the input channel carries one set of four light samples and
// gives exactly one result transfer with the pan and tilt directions, the new
// servo angles and the inverted PWM low time of each servo. The block is a
// five-stage pipeline that accepts one sample set per clock cycle while the
// output side is not stalling and no span division runs; each stage holds its
// item while the next one is full. The servo angles update in the second stage,
// so consecutive sample sets see each other's moves in order. Writing
// pulse_min_ns or pulse_max_ns starts a reciprocal division of the pulse span by
// 180, a quotient step then a remainder step; during the division both the input
// and configuration channels hold ready low.
module dual_axis_light_tracker
  import dalt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = dalt_pkg::SampleBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dalt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dalt_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Sample input channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                top_left_i,
  input  logic [SAMPLE_BITS-1:0]                top_right_i,
  input  logic [SAMPLE_BITS-1:0]                bottom_left_i,
  input  logic [SAMPLE_BITS-1:0]                bottom_right_i,
  // Result output channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dalt_pkg::DIR_W-1:0]     pan_direction_o,
  output logic signed [dalt_pkg::DIR_W-1:0]     tilt_direction_o,
  output logic [dalt_pkg::ANGLE_W-1:0]          pan_angle_o,
  output logic [dalt_pkg::ANGLE_W-1:0]          tilt_angle_o,
  output logic [dalt_pkg::TIME_W-1:0]           pan_low_time_ns_o,
  output logic [dalt_pkg::TIME_W-1:0]           tilt_low_time_ns_o
);

  // Width that holds a signed difference of averages and the tolerance.
  localparam int unsigned DW = ((SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W) + 2;

  // Axis lanes: 0 is pan, 1 is tilt.
  localparam int unsigned NUM_AXES = 2;

  // Configuration registers.
  logic [TOL_W-1:0]  tolerance_q;
  logic [STEP_W-1:0] angle_step_q;
  logic [TIME_W-1:0] period_q;
  logic [TIME_W-1:0] pulse_min_q;
  logic [TIME_W-1:0] pulse_max_q;

  // Span divider state; when idle, div_num_q holds span / 180 and div_rem_q
  // holds span % 180.
  logic                   div_start_q;
  logic                   div_fix_q;
  logic [SPAN_Q_W-1:0]    div_num_q;
  logic [SPAN_R_W-1:0]    div_rem_q;
  logic                   busy;
  logic [TIME_W-1:0]      span;
  logic [SPAN_PROD_W-1:0] div_prod;
  logic [TIME_W-1:0]      div_back;
  logic                   cfg_write;

  // Pipeline valid bits and per-stage ready.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_xfer;
  logic adv1;

  // Stage 1: registered samples.
  logic [SAMPLE_BITS-1:0] tl_q, tr_q, bl_q, br_q;

  // Servo positions.
  logic [ANGLE_W-1:0] pos_q [NUM_AXES];
  logic [ANGLE_W-1:0] pos_d [NUM_AXES];

  // Stage 1 comparison logic.
  logic [SAMPLE_BITS:0]   sum_top, sum_bot, sum_left, sum_right;
  logic signed [DIR_W-1:0] dir1 [NUM_AXES];

  // Stages 2 to 5.
  logic signed [DIR_W-1:0] dir2_q [NUM_AXES];
  logic signed [DIR_W-1:0] dir3_q [NUM_AXES];
  logic signed [DIR_W-1:0] dir4_q [NUM_AXES];
  logic signed [DIR_W-1:0] dir5_q [NUM_AXES];
  logic [ANGLE_W-1:0]      ang2_q [NUM_AXES];
  logic [ANGLE_W-1:0]      ang3_q [NUM_AXES];
  logic [ANGLE_W-1:0]      ang4_q [NUM_AXES];
  logic [ANGLE_W-1:0]      ang5_q [NUM_AXES];
  logic [ACT_W-1:0]        hi3_q  [NUM_AXES];
  logic [FRAC_W-1:0]       num3_q [NUM_AXES];
  logic [ACT_W-1:0]        act4_q [NUM_AXES];
  logic [ACT_W:0]          used4  [NUM_AXES];
  logic [TIME_W-1:0]       low5_q [NUM_AXES];

  // Signed difference of two averages against the dead band.
  function automatic logic signed [DIR_W-1:0] axis_dir(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b,
    input logic [TOL_W-1:0]       tol
  );
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] tol_s;
    diff  = signed'(DW'(a)) - signed'(DW'(b));
    tol_s = signed'(DW'(tol));
    if (diff > tol_s) begin
      return DIR_POS;
    end else if (diff < -tol_s) begin
      return DIR_NEG;
    end
    return DIR_HOLD;
  endfunction

  // Move an angle by the step in the given direction, clamped to 0..180.
  function automatic logic [ANGLE_W-1:0] move_angle(
    input logic [ANGLE_W-1:0]      pos,
    input logic signed [DIR_W-1:0] dir,
    input logic [STEP_W-1:0]       step
  );
    logic [ANGLE_W:0] up;
    up = {1'b0, pos} + (ANGLE_W + 1)'(step);
    if (dir == DIR_POS) begin
      return (up > (ANGLE_W + 1)'(ANGLE_MAX)) ? ANGLE_MAX : up[ANGLE_W-1:0];
    end else if (dir == DIR_NEG) begin
      return ((ANGLE_W + 1)'(pos) > (ANGLE_W + 1)'(step)) ?
             ANGLE_W'(pos - ANGLE_W'(step)) : '0;
    end
    return pos;
  endfunction

  // Handshakes.
  assign busy        = div_start_q || div_fix_q;
  assign cfg_ready_o = !busy;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1 && !busy;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign adv1       = v1_q && rdy2;

  // Configuration register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q  <= TOL_RST;
      angle_step_q <= STEP_RST;
      period_q     <= PERIOD_RST;
      pulse_min_q  <= PULSE_MIN_RST;
      pulse_max_q  <= PULSE_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_TOLERANCE:    tolerance_q  <= cfg_data_i[TOL_W-1:0];
        CFG_ANGLE_STEP:   angle_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_PERIOD_NS:    period_q     <= cfg_data_i;
        CFG_PULSE_MIN_NS: pulse_min_q  <= cfg_data_i;
        CFG_PULSE_MAX_NS: pulse_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pulse span, zero when the maximum lies below the minimum.
  assign span = (pulse_max_q > pulse_min_q) ? (pulse_max_q - pulse_min_q) : '0;

  // Quotient by reciprocal multiplication, and the quotient times 180 for the
  // remainder.
  assign div_prod = SPAN_PROD_W'(span[TIME_W-1:SPAN_PRE_SH]) * SPAN_PROD_W'(SPAN_RCP);
  assign div_back = TIME_W'(div_num_q) * TIME_W'(SPAN_DIV);

  // Span divider, restarted by a write to either pulse register: the quotient
  // is taken in the start state and the remainder in the fix state that follows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start_q <= 1'b0;
      div_fix_q   <= 1'b0;
      div_num_q   <= SPAN_Q_RST;
      div_rem_q   <= SPAN_R_RST;
    end else if (cfg_write) begin
      div_start_q <= (cfg_index_i == CFG_PULSE_MIN_NS) ||
                     (cfg_index_i == CFG_PULSE_MAX_NS);
    end else if (div_start_q) begin
      div_start_q <= 1'b0;
      div_fix_q   <= 1'b1;
      div_num_q   <= div_prod[SPAN_RCP_SH +: SPAN_Q_W];
    end else if (div_fix_q) begin
      div_fix_q <= 1'b0;
      div_rem_q <= SPAN_R_W'(span - div_back);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_xfer || (v1_q && !rdy2);
      v2_q <= adv1 || (v2_q && !rdy3);
      v3_q <= (v2_q && rdy3) || (v3_q && !rdy4);
      v4_q <= (v3_q && rdy4) || (v4_q && !rdy5);
      v5_q <= (v4_q && rdy5) || (v5_q && !out_ready_i);
    end
  end

  // Stage 1: sample register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tl_q <= top_left_i;
      tr_q <= top_right_i;
      bl_q <= bottom_left_i;
      br_q <= bottom_right_i;
    end
  end

  // Pair sums; each average is the sum shifted down by one.
  assign sum_top   = {1'b0, tl_q} + {1'b0, tr_q};
  assign sum_bot   = {1'b0, bl_q} + {1'b0, br_q};
  assign sum_left  = {1'b0, tl_q} + {1'b0, bl_q};
  assign sum_right = {1'b0, tr_q} + {1'b0, br_q};

  // Pan follows the brighter side, tilt moves toward the bottom when it is brighter.
  assign dir1[0] = axis_dir(sum_left[SAMPLE_BITS:1], sum_right[SAMPLE_BITS:1], tolerance_q);
  assign dir1[1] = axis_dir(sum_bot[SAMPLE_BITS:1], sum_top[SAMPLE_BITS:1], tolerance_q);

  // Servo positions advance with each sample set leaving stage 1.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      pos_d[i] = move_angle(pos_q[i], dir1[i], angle_step_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_q[i] <= ANGLE_HOME;
      end
    end else if (adv1) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_q[i] <= pos_d[i];
      end
    end
  end

  // Stage 2: direction and new angle.
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dir2_q[i] <= dir1[i];
        ang2_q[i] <= pos_d[i];
      end
    end
  end

  // Stage 3: angle times span quotient, and the biased remainder product.
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dir3_q[i] <= dir2_q[i];
        ang3_q[i] <= ang2_q[i];
        hi3_q[i]  <= ACT_W'(ang2_q[i] * div_num_q);
        num3_q[i] <= FRAC_W'(ang2_q[i] * div_rem_q) + CEIL_BIAS;
      end
    end
  end

  // Stage 4: active pulse time, the ceiling of angle * span / 180.
  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dir4_q[i] <= dir3_q[i];
        ang4_q[i] <= ang3_q[i];
        act4_q[i] <= hi3_q[i] +
                     ACT_W'((FRAC_W + RECIP_W)'(num3_q[i] * RECIP_180) >> RECIP_SH);
      end
    end
  end

  // Time used by the minimum pulse and the active part.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      used4[i] = (ACT_W + 1)'(pulse_min_q) + (ACT_W + 1)'(act4_q[i]);
    end
  end

  // Stage 5: low time, saturated at zero.
  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dir5_q[i] <= dir4_q[i];
        ang5_q[i] <= ang4_q[i];
        low5_q[i] <= (used4[i] >= (ACT_W + 1)'(period_q)) ? '0 :
                     TIME_W'((ACT_W + 1)'(period_q) - used4[i]);
      end
    end
  end

  // Result ports.
  assign out_valid_o        = v5_q;
  assign pan_direction_o    = dir5_q[0];
  assign tilt_direction_o   = dir5_q[1];
  assign pan_angle_o        = ang5_q[0];
  assign tilt_angle_o       = ang5_q[1];
  assign pan_low_time_ns_o  = low5_q[0];
  assign tilt_low_time_ns_o = low5_q[1];

endmodule

### tb/tb_dual_axis_light_tracker.sv
// Self-checking testbench for the dual-axis light tracker with a built-in servo predictor.
module tb_dual_axis_light_tracker;
  import dalt_pkg::*;

  localparam int unsigned SAMPLE_W    = SampleBitsDef;
  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int unsigned TIME_MAX    = (1 << TIME_W) - 1;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          STALL_LIMIT = 3000;
  localparam int          PHASE_ITEMS = 85;
  localparam int          PHASES      = 7;
  localparam int          BURST_ITEMS = 40;

  // Register indexes past the last register; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] pan_dir;
    logic signed [DIR_W-1:0] tilt_dir;
    logic [ANGLE_W-1:0]      pan_angle;
    logic [ANGLE_W-1:0]      tilt_angle;
    logic [TIME_W-1:0]       pan_low;
    logic [TIME_W-1:0]       tilt_low;
  } servo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic    in_valid = 1'b0;
  logic    in_ready_o;
  sample_t top_left = '0;
  sample_t top_right = '0;
  sample_t bottom_left = '0;
  sample_t bottom_right = '0;

  logic                    out_valid_o;
  logic                    out_ready = 1'b0;
  logic signed [DIR_W-1:0] pan_direction_o;
  logic signed [DIR_W-1:0] tilt_direction_o;
  logic [ANGLE_W-1:0]      pan_angle_o;
  logic [ANGLE_W-1:0]      tilt_angle_o;
  logic [TIME_W-1:0]       pan_low_time_ns_o;
  logic [TIME_W-1:0]       tilt_low_time_ns_o;

  // Shadow copy of the block's registers and servo angles.
  logic [TOL_W-1:0]   tol_reg = TOL_RST;
  logic [STEP_W-1:0]  step_reg = STEP_RST;
  logic [TIME_W-1:0]  period_reg = PERIOD_RST;
  logic [TIME_W-1:0]  pulse_min_reg = PULSE_MIN_RST;
  logic [TIME_W-1:0]  pulse_max_reg = PULSE_MAX_RST;
  logic [ANGLE_W-1:0] pan_pos = ANGLE_HOME;
  logic [ANGLE_W-1:0] tilt_pos = ANGLE_HOME;

  servo_result_t pending_results[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  dual_axis_light_tracker i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .top_left_i         (top_left),
    .top_right_i        (top_right),
    .bottom_left_i      (bottom_left),
    .bottom_right_i     (bottom_right),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .pan_direction_o    (pan_direction_o),
    .tilt_direction_o   (tilt_direction_o),
    .pan_angle_o        (pan_angle_o),
    .tilt_angle_o       (tilt_angle_o),
    .pan_low_time_ns_o  (pan_low_time_ns_o),
    .tilt_low_time_ns_o (tilt_low_time_ns_o)
  );

  initial forever #5 clk = ~clk;

  // Direction of one axis from two pair averages and the dead band.
  function automatic logic signed [DIR_W-1:0] axis_direction(int a, int b);
    int d;
    d = a - b;
    if (d > int'(tol_reg)) return DIR_POS;
    if (d < -int'(tol_reg)) return DIR_NEG;
    return DIR_HOLD;
  endfunction

  // New servo angle after one move, clamped to the servo range.
  function automatic logic [ANGLE_W-1:0] move_servo(logic [ANGLE_W-1:0] pos,
                                                    logic signed [DIR_W-1:0] dir);
    int p;
    p = int'(pos);
    if (dir == DIR_POS) begin
      p = p + int'(step_reg);
      if (p > int'(ANGLE_FULL)) p = int'(ANGLE_FULL);
    end else if (dir == DIR_NEG) begin
      p = (p > int'(step_reg)) ? p - int'(step_reg) : 0;
    end
    return ANGLE_W'(p);
  endfunction

  // Inverted PWM low time for one servo angle, saturated at zero.
  function automatic logic [TIME_W-1:0] servo_low_time(logic [ANGLE_W-1:0] ang);
    longint unsigned span;
    longint unsigned active;
    longint unsigned used;
    span = 0;
    if (pulse_max_reg > pulse_min_reg) span = pulse_max_reg - pulse_min_reg;
    active = (longint'(ang) * span + ANGLE_FULL - 1) / ANGLE_FULL;
    used = longint'(pulse_min_reg) + active;
    if (used >= longint'(period_reg)) return '0;
    return TIME_W'(longint'(period_reg) - used);
  endfunction

  // One tracking step on the shadow state: averages, directions, angles, low times.
  function automatic servo_result_t track_step(sample_t tl, sample_t tr,
                                               sample_t bl, sample_t br);
    servo_result_t r;
    int avg_top;
    int avg_bot;
    int avg_left;
    int avg_right;
    avg_top   = (int'(tl) + int'(tr)) >> 1;
    avg_bot   = (int'(bl) + int'(br)) >> 1;
    avg_left  = (int'(tl) + int'(bl)) >> 1;
    avg_right = (int'(tr) + int'(br)) >> 1;
    r.pan_dir  = axis_direction(avg_left, avg_right);
    r.tilt_dir = axis_direction(avg_bot, avg_top);
    pan_pos  = move_servo(pan_pos, r.pan_dir);
    tilt_pos = move_servo(tilt_pos, r.tilt_dir);
    r.pan_angle  = pan_pos;
    r.tilt_angle = tilt_pos;
    r.pan_low    = servo_low_time(pan_pos);
    r.tilt_low   = servo_low_time(tilt_pos);
    return r;
  endfunction

  // Register write as the block sees it; unknown indexes change nothing.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TOLERANCE:    tol_reg = data[TOL_W-1:0];
      CFG_ANGLE_STEP:   step_reg = data[STEP_W-1:0];
      CFG_PERIOD_NS:    period_reg = data[TIME_W-1:0];
      CFG_PULSE_MIN_NS: pulse_min_reg = data[TIME_W-1:0];
      CFG_PULSE_MAX_NS: pulse_max_reg = data[TIME_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic signed [TIME_W:0] want,
                             logic signed [TIME_W:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Watch every transfer at the rising edge: predict inputs, check results.
  always @(posedge clk) begin : monitor
    servo_result_t want;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with no sample set outstanding", $time);
        end else begin
          want = pending_results.pop_front();
          check_field("pan_direction", want.pan_dir, pan_direction_o);
          check_field("tilt_direction", want.tilt_dir, tilt_direction_o);
          check_field("pan_angle", want.pan_angle, pan_angle_o);
          check_field("tilt_angle", want.tilt_angle, tilt_angle_o);
          check_field("pan_low_time_ns", want.pan_low, pan_low_time_ns_o);
          check_field("tilt_low_time_ns", want.tilt_low, tilt_low_time_ns_o);
        end
      end
      if (cfg_valid && cfg_ready_o) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready_o)
        pending_results.push_back(track_step(top_left, top_right, bottom_left,
                                             bottom_right));
      if ((out_valid_o && out_ready) || (cfg_valid && cfg_ready_o) ||
          (in_valid && in_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls per result, plus a long hold-off on request.
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  // Offer one sample set after a random gap and wait for its transfer.
  task automatic send_samples(sample_t tl, sample_t tr, sample_t bl, sample_t br);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    top_left     <= tl;
    top_right    <= tr;
    bottom_left  <= bl;
    bottom_right <= br;
    do @(posedge clk); while (!in_ready_o);
  endtask

  // Stop offering samples and let every outstanding result come out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load all five registers once the block is idle; narrow fields get junk upper bits.
  task automatic set_config(int tol, int step, int period, int pmin, int pmax);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = CFG_DATA_W'($urandom);
    data[TOL_W-1:0] = TOL_W'(tol);
    write_reg(CFG_TOLERANCE, data);
    data = CFG_DATA_W'($urandom);
    data[STEP_W-1:0] = STEP_W'(step);
    write_reg(CFG_ANGLE_STEP, data);
    write_reg(CFG_PERIOD_NS, CFG_DATA_W'(period));
    write_reg(CFG_PULSE_MIN_NS, CFG_DATA_W'(pmin));
    write_reg(CFG_PULSE_MAX_NS, CFG_DATA_W'(pmax));
  endtask

  // Random sample set: fully random, one bright edge near the dead band or with a random margin, or flat.
  task automatic random_samples(output sample_t tl, output sample_t tr,
                                output sample_t bl, output sample_t br);
    int mode;
    int hi;
    int lo;
    int margin;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      tl = sample_t'($urandom);
      tr = sample_t'($urandom);
      bl = sample_t'($urandom);
      br = sample_t'($urandom);
    end else begin
      hi = $urandom_range(0, SAMPLE_MAX - 1);
      margin = (mode == 9) ? 0 : int'(tol_reg) + $urandom_range(0, 4) - 2;
      if (mode > 7) margin = (mode == 9) ? 0 : $urandom_range(0, SAMPLE_MAX);
      if (margin < 0) margin = 0;
      lo = (hi > margin) ? hi - margin : 0;
      case ($urandom_range(0, 3))
        0: begin
          tl = sample_t'(hi); tr = sample_t'(hi); bl = sample_t'(lo); br = sample_t'(lo);
        end
        1: begin
          tl = sample_t'(lo); tr = sample_t'(lo); bl = sample_t'(hi); br = sample_t'(hi);
        end
        2: begin
          tl = sample_t'(hi); tr = sample_t'(lo); bl = sample_t'(hi); br = sample_t'(lo);
        end
        default: begin
          tl = sample_t'(lo); tr = sample_t'(hi); bl = sample_t'(lo); br = sample_t'(hi);
        end
      endcase
      tl = sample_t'(tl + $urandom_range(0, 1));
      tr = sample_t'(tr + $urandom_range(0, 1));
      bl = sample_t'(bl + $urandom_range(0, 1));
      br = sample_t'(br + $urandom_range(0, 1));
    end
  endtask

  // Reset settings: dead band edges, both pan moves, tilt driven into its lower clamp.
  task automatic test_directed_tracking();
    idle_on = 1'b1;
    send_samples('0, '0, '0, '0);
    send_samples(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_samples(120, 100, 120, 100);
    send_samples(121, 100, 121, 100);
    send_samples('0, SAMPLE_MAX, '0, SAMPLE_MAX);
    repeat (10) send_samples(SAMPLE_MAX, SAMPLE_MAX, '0, '0);
  endtask

  // Register corners: zero and full dead band, zero and oversized step,
  // saturated low time, inverted pulse range and writes to unused indexes.
  task automatic test_register_corners();
    set_config(0, STEP_RST, PERIOD_RST, PULSE_MIN_RST, PULSE_MAX_RST);
    send_samples(1, '0, '0, '0);
    send_samples(1, '0, 1, '0);
    set_config(0, 200, PERIOD_RST, PULSE_MIN_RST, PULSE_MAX_RST);
    send_samples('0, '0, SAMPLE_MAX, SAMPLE_MAX);
    send_samples('0, SAMPLE_MAX, '0, SAMPLE_MAX);
    set_config(0, 0, PERIOD_RST, PULSE_MIN_RST, PULSE_MAX_RST);
    send_samples(SAMPLE_MAX, '0, SAMPLE_MAX, '0);
    set_config(SAMPLE_MAX, STEP_RST, 1, PULSE_MIN_RST, PULSE_MAX_RST);
    send_samples(SAMPLE_MAX, '0, '0, '0);
    set_config(TOL_RST, 255, TIME_MAX, 0, TIME_MAX);
    send_samples(SAMPLE_MAX, '0, SAMPLE_MAX, '0);
    send_samples(SAMPLE_MAX, SAMPLE_MAX, '0, '0);
    set_config(TOL_RST, STEP_RST, TIME_MAX, TIME_MAX - 5, 1000);
    send_samples('0, '0, SAMPLE_MAX, SAMPLE_MAX);
    wait_idle();
    for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    send_samples('0, SAMPLE_MAX, '0, SAMPLE_MAX);
  endtask

  // Random register settings per phase, with a mix of random, bright-edge and flat samples.
  task automatic test_random_tracking();
    int tol;
    int step;
    int period;
    int pmin;
    int pmax;
    sample_t tl;
    sample_t tr;
    sample_t bl;
    sample_t br;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = SAMPLE_MAX;
        2: tol = $urandom_range(0, 200);
        default: tol = $urandom_range(0, SAMPLE_MAX);
      endcase
      case ($urandom_range(0, 5))
        0: step = 0;
        1: step = ANGLE_FULL;
        2: step = 255;
        default: step = $urandom_range(1, 30);
      endcase
      case ($urandom_range(0, 3))
        0: period = 1;
        1: period = TIME_MAX;
        2: period = PERIOD_RST;
        default: period = $urandom_range(1, TIME_MAX);
      endcase
      case ($urandom_range(0, 4))
        0: begin pmin = PULSE_MIN_RST; pmax = PULSE_MAX_RST; end
        1: begin pmin = 0; pmax = TIME_MAX; end
        2: begin pmin = TIME_MAX; pmax = $urandom_range(0, TIME_MAX); end
        3: begin
          pmax = $urandom_range(0, TIME_MAX / 2);
          pmin = $urandom_range(pmax, TIME_MAX);
        end
        default: begin
          pmin = $urandom_range(0, TIME_MAX);
          pmax = $urandom_range(0, TIME_MAX);
        end
      endcase
      set_config(tol, step, period, pmin, pmax);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Switch between idling and back-to-back stretches now and then.
        if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
        random_samples(tl, tr, bl, br);
        send_samples(tl, tr, bl, br);
      end
    end
    idle_on = 1'b1;
  endtask

  // Long receiver hold-off while samples keep coming, so the pipeline backs up.
  task automatic test_backpressure();
    sample_t tl;
    sample_t tr;
    sample_t bl;
    sample_t br;
    set_config(TOL_RST, STEP_RST, PERIOD_RST, PULSE_MIN_RST, PULSE_MAX_RST);
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < BURST_ITEMS; n++) begin
      random_samples(tl, tr, bl, br);
      send_samples(tl, tr, bl, br);
    end
    idle_on = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_directed_tracking();
    test_register_corners();
    test_random_tracking();
    test_backpressure();
    wait_idle();
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
